/* sv/bcf_pkg.sv */
`timescale 1ns / 1ps

package bcf_pkg;

	localparam int TickWidth   = 32;
	localparam int RegWidth    = 16;
	localparam int IndexWidth  = 3;
	localparam int PhaseWidth  = 4;
	localparam int InDataWidth = 40;
	localparam int OutDataWidth = 8;

	typedef enum logic [IndexWidth-1:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_DC_WINDOW = 3'd1,
		REG_LONG      = 3'd2,
		REG_DC_ON     = 3'd3,
		REG_LONG_ON   = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_CLICK  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef struct packed {
		logic [RegWidth-1:0] debounce_ticks;
		logic [RegWidth-1:0] double_click_window;
		logic [RegWidth-1:0] long_press_ticks;
		logic                double_click_on;
		logic                long_press_on;
	} cfg_t;

endpackage

/* sv/bcf_cfg_regs.sv */
`timescale 1ns / 1ps

module bcf_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bcf_pkg::IndexWidth-1:0]     cfg_index,
	input  logic [bcf_pkg::RegWidth-1:0]       cfg_data,
	output bcf_pkg::cfg_t                      cfg
);
	import bcf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks      <= RegWidth'(20);
			cfg_q.double_click_window <= RegWidth'(300);
			cfg_q.long_press_ticks    <= RegWidth'(1000);
			cfg_q.double_click_on     <= 1'b1;
			cfg_q.long_press_on       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce_ticks      <= cfg_data;
				REG_DC_WINDOW: cfg_q.double_click_window <= cfg_data;
				REG_LONG:      cfg_q.long_press_ticks    <= cfg_data;
				REG_DC_ON:     cfg_q.double_click_on     <= cfg_data[0];
				REG_LONG_ON:   cfg_q.long_press_on       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/bcf_core.sv */
`timescale 1ns / 1ps

module bcf_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bcf_pkg::cfg_t                     cfg,
	input  logic                              en,
	input  logic                              key_down,
	input  logic [bcf_pkg::TickWidth-1:0]     now_tick,
	output bcf_pkg::event_t                   event_code,
	output logic [bcf_pkg::PhaseWidth-1:0]    fsm_phase
);
	import bcf_pkg::*;

	typedef enum logic [PhaseWidth-1:0] {
		PH_IDLE    = 4'd0,
		PH_PDEB    = 4'd1,
		PH_PRESS   = 4'd2,
		PH_RDEB    = 4'd3,
		PH_RELEASE = 4'd4,
		PH_WAITDC  = 4'd5,
		PH_DCLICK  = 4'd6,
		PH_HOLD    = 4'd7,
		PH_LONG    = 4'd8,
		PH_WAITLR  = 4'd9
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [TickWidth-1:0]   mark_time_q, mark_time_d;
	logic [TickWidth-1:0]   window_start_q, window_start_d;
	logic [TickWidth-1:0]   hold_start_q, hold_start_d;
	logic [1:0]             click_count_q, click_count_d;
	event_t                 ev;

	logic [TickWidth-1:0]   since_mark, since_window, since_hold;
	logic [TickWidth-1:0]   debounce_x, window_x, long_x;

	assign since_mark   = now_tick - mark_time_q;
	assign since_window = now_tick - window_start_q;
	assign since_hold   = now_tick - hold_start_q;
	assign debounce_x   = TickWidth'(cfg.debounce_ticks);
	assign window_x     = TickWidth'(cfg.double_click_window);
	assign long_x       = TickWidth'(cfg.long_press_ticks);

	always_comb begin
		phase_d        = phase_q;
		mark_time_d    = mark_time_q;
		window_start_d = window_start_q;
		hold_start_d   = hold_start_q;
		click_count_d  = click_count_q;
		ev             = EV_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (key_down) begin
					mark_time_d = now_tick;
					phase_d     = PH_PDEB;
				end
			end
			PH_PDEB: begin
				if (!key_down) begin
					phase_d = PH_IDLE;
				end else if (since_mark > debounce_x) begin
					phase_d = PH_PRESS;
				end
			end
			PH_PRESS: begin
				if (cfg.long_press_on) begin
					hold_start_d = now_tick;
					phase_d      = PH_HOLD;
				end else if (!key_down) begin
					mark_time_d = now_tick;
					phase_d     = PH_RDEB;
				end
			end
			PH_RDEB: begin
				if (key_down) begin
					phase_d = PH_PRESS;
				end else if (since_mark > debounce_x) begin
					phase_d = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (cfg.double_click_on) begin
					click_count_d = click_count_q + 2'd1;
					if (click_count_d == 2'd1) begin
						window_start_d = now_tick;
						phase_d        = PH_WAITDC;
					end else if (click_count_d == 2'd2) begin
						phase_d = PH_DCLICK;
					end
				end else begin
					ev      = EV_CLICK;
					phase_d = PH_IDLE;
				end
			end
			PH_WAITDC: begin
				if (key_down) begin
					mark_time_d = now_tick;
					phase_d     = PH_PDEB;
				end else if (since_window > window_x) begin
					click_count_d = 2'd0;
					ev            = EV_CLICK;
					phase_d       = PH_IDLE;
				end
			end
			PH_DCLICK: begin
				ev             = EV_DOUBLE;
				window_start_d = '0;
				click_count_d  = 2'd0;
				phase_d        = PH_IDLE;
			end
			PH_HOLD: begin
				if (!key_down) begin
					if (cfg.double_click_on && (since_hold > window_x)) begin
						phase_d = PH_IDLE;
					end else begin
						mark_time_d = now_tick;
						phase_d     = PH_RDEB;
					end
				end else if (since_hold >= long_x) begin
					hold_start_d = '0;
					phase_d      = PH_LONG;
				end
			end
			PH_LONG: begin
				ev      = EV_LONG;
				phase_d = PH_WAITLR;
			end
			PH_WAITLR: begin
				if (!key_down) begin
					if (cfg.double_click_on) begin
						click_count_d = 2'd0;
					end
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			mark_time_q    <= '0;
			window_start_q <= '0;
			hold_start_q   <= '0;
			click_count_q  <= 2'd0;
		end else if (en) begin
			phase_q        <= phase_d;
			mark_time_q    <= mark_time_d;
			window_start_q <= window_start_d;
			hold_start_q   <= hold_start_d;
			click_count_q  <= click_count_d;
		end
	end

	assign event_code = ev;
	assign fsm_phase  = phase_d;

endmodule

/* sv/button_click_fsm.sv */
`timescale 1ns / 1ps

// m_tvalid rises once an input transfer has passed the input register, then
// the result register; a stall on m_tready can hold the poll between the two.
// Throughput: one poll per cycle while the result register is empty or m_tready is high.
// Reset: arst_n clears the machine to idle, the click count and times to zero,
// and the registers to debounce 20, window 300, long press 1000, both enables on.
module button_click_fsm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bcf_pkg::IndexWidth-1:0]       cfg_index,
	input  logic [bcf_pkg::RegWidth-1:0]         cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bcf_pkg::InDataWidth-1:0]      s_tdata,  // key_down, now_tick[31:0]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bcf_pkg::OutDataWidth-1:0]     m_tdata   // event_code[1:0], fsm_phase[3:0]
);
	import bcf_pkg::*;

	cfg_t                  cfg;
	logic                  valid_s1;
	logic                  key_s1;
	logic [TickWidth-1:0]  now_s1;
	logic                  advance;
	event_t                ev;
	logic [PhaseWidth-1:0] phase_nxt;
	logic                  out_valid_q;
	logic [OutDataWidth-1:0] out_data_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1 <= s_tdata[0];
			now_s1 <= s_tdata[TickWidth:1];
		end
	end

	bcf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcf_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.en         (advance),
		.key_down   (key_s1),
		.now_tick   (now_s1),
		.event_code (ev),
		.fsm_phase  (phase_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, phase_nxt, ev};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
